### sv/jscan_pkg.sv
// Shared constants, types and codes for the JSON structural scanner.
package jscan_pkg;

  localparam int MAX_DEPTH  = 16;
  localparam int MAX_CHUNKS = 64;
  localparam int MAX_LENGTH = 65536;

  localparam int DEPTH_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FILL_W  = $clog2(MAX_DEPTH + 1);
  localparam int POS_W   = $clog2(MAX_LENGTH + 1);
  localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);

  // fixed field widths
  localparam int OFF_W     = 16;
  localparam int LEN_W     = 17;
  localparam int CNT_OUT_W = 7;
  localparam int KIND_W    = 2;
  localparam int TDATA_W   = 56;
  localparam int TUSER_W   = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_OBJ  = 2'd1,
    MARK_ARR  = 2'd2,
    MARK_KEY  = 2'd3
  } mark_t;

  localparam logic [KIND_W-1:0] KIND_STR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OBJ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ARR = 2'd2;

  localparam logic REC_CHUNK = 1'b0;
  localparam logic REC_COUNT = 1'b1;

  typedef struct packed {
    logic                 record_type;
    logic [KIND_W-1:0]    chunk_kind;
    logic [OFF_W-1:0]     header_offset;
    logic [OFF_W-1:0]     data_offset;
    logic [LEN_W-1:0]     data_length;
    logic [CNT_OUT_W-1:0] chunk_count;
    logic                 last;
  } result_t;

  // results of one byte: chunk first, then count record
  typedef struct packed {
    logic    chunk_v;
    logic    count_v;
    result_t chunk;
    result_t count;
  } push_t;

endpackage

### sv/json_structural_chunk_scanner.sv
// Top level of the JSON structural scanner: input register, core, result queue.
//
//  channel | dir | tdata                          | tuser                  | tlast
//  --------+-----+--------------------------------+------------------------+----------
//  in_     | in  | data_byte[7:0]                 | first_byte             | last_byte
//  out_    | out | header_offset, data_offset,    | record_type,           | last
//          |     | data_length, chunk_count       | chunk_kind             |
//
//  One byte word per cycle while in_tready is high. A word lands in the input
//  register; once the queue can take two results the core decodes it, updates
//  the scan state and bracket stack, and pushes zero, one or two result words
//  into a four-entry queue. The input register drains whenever the queue holds
//  two results or fewer; under an output stall in_tready drops once three
//  results are queued, i.e. after two or three result-making words (words that
//  make none never block). Sustained rate is one byte per cycle while out_
//  takes one result per cycle; a byte giving both a chunk and a count record
//  puts two results on out_. rst_n is synchronous; no clearing pass is needed.
module json_structural_chunk_scanner (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic                            in_tuser,   // first_byte
  input  logic                            in_tlast,   // last_byte

  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] header_offset, [31:16] data_offset, [48:32] data_length,
  // [55:49] chunk_count
  output logic [jscan_pkg::TDATA_W-1:0]   out_tdata,
  // [0] record_type, [2:1] chunk_kind
  output logic [jscan_pkg::TUSER_W-1:0]   out_tuser,
  output logic                            out_tlast
);

  // input register
  logic       iv_r;
  logic [7:0] ib_r;
  logic       if_r, il_r;

  logic               space2, proc;
  jscan_pkg::push_t   push;
  jscan_pkg::result_t res;

  // the held word is decoded once the queue can take both possible results
  assign proc      = iv_r && space2;
  assign in_tready = !iv_r || space2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      iv_r <= 1'b1;
    end else if (proc) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ib_r <= in_tdata;
      if_r <= in_tuser;
      il_r <= in_tlast;
    end
  end

  jscan_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .proc       (proc),
    .data_byte  (ib_r),
    .first_byte (if_r),
    .last_byte  (il_r),
    .push       (push)
  );

  jscan_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space2    (space2),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (res)
  );

  assign out_tdata = {res.chunk_count, res.data_length, res.data_offset, res.header_offset};
  assign out_tuser = {res.chunk_kind, res.record_type};
  assign out_tlast = res.last;

endmodule

### sv/jscan_core.sv
// Scan state, bracket stack and per-byte decode of the JSON scanner.
module jscan_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                proc,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic                last_byte,
  output jscan_pkg::push_t    push
);

  logic [jscan_pkg::POS_W-1:0]  pos_r,    pos_nxt;
  logic [jscan_pkg::FILL_W-1:0] fill_r,   fill_nxt;
  logic [jscan_pkg::CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic                         str_r,    str_nxt;
  logic                         skip_r,   skip_nxt;
  logic [jscan_pkg::OFF_W-1:0]  sstart_r, sstart_nxt;
  logic                         stop_r,   stop_nxt;

  logic [jscan_pkg::OFF_W-1:0] offs_r  [jscan_pkg::MAX_DEPTH];
  jscan_pkg::mark_t            marks_r [jscan_pkg::MAX_DEPTH];

  // state as seen by this byte (first_byte clears it)
  logic [jscan_pkg::POS_W-1:0]  e_pos;
  logic [jscan_pkg::FILL_W-1:0] e_fill;
  logic [jscan_pkg::CNT_W-1:0]  e_cnt;
  logic                         e_str, e_skip, e_stop;
  logic [jscan_pkg::OFF_W-1:0]  e_sstart;

  logic [jscan_pkg::DEPTH_W-1:0] top_idx, push_idx;
  logic [jscan_pkg::OFF_W-1:0]   top_off, cur_off;
  jscan_pkg::mark_t              top_mark;

  logic                          off_we, mark_we;
  logic [jscan_pkg::DEPTH_W-1:0] wr_idx;
  jscan_pkg::mark_t              wr_mark;

  logic                          chunk_v;
  logic [jscan_pkg::KIND_W-1:0]  kind;
  logic [jscan_pkg::OFF_W-1:0]   hoff, doff;
  logic [jscan_pkg::LEN_W-1:0]   dlen;

  always_comb begin
    e_pos    = first_byte ? '0 : pos_r;
    e_fill   = first_byte ? '0 : fill_r;
    e_cnt    = first_byte ? '0 : cnt_r;
    e_str    = first_byte ? 1'b0 : str_r;
    e_skip   = first_byte ? 1'b0 : skip_r;
    e_sstart = first_byte ? '0 : sstart_r;
    e_stop   = first_byte ? 1'b0 : stop_r;
  end

  assign top_idx  = jscan_pkg::DEPTH_W'(e_fill - 1'b1);
  assign push_idx = jscan_pkg::DEPTH_W'(e_fill);
  assign top_off  = offs_r[top_idx];
  assign top_mark = marks_r[top_idx];
  assign cur_off  = jscan_pkg::OFF_W'(e_pos);

  always_comb begin
    pos_nxt    = e_pos;
    fill_nxt   = e_fill;
    cnt_nxt    = e_cnt;
    str_nxt    = e_str;
    skip_nxt   = e_skip;
    sstart_nxt = e_sstart;
    stop_nxt   = e_stop;
    off_we     = 1'b0;
    mark_we    = 1'b0;
    wr_idx     = top_idx;
    wr_mark    = jscan_pkg::MARK_NONE;
    chunk_v    = 1'b0;
    kind       = jscan_pkg::KIND_STR;
    hoff       = top_off;
    doff       = top_off;
    dlen       = jscan_pkg::LEN_W'(e_pos) + 1'b1 - jscan_pkg::LEN_W'(top_off);

    if (e_pos < jscan_pkg::POS_W'(jscan_pkg::MAX_LENGTH)) begin
      pos_nxt = e_pos + 1'b1;
      if (!e_stop) begin
        if (e_str) begin
          if (e_skip) begin
            skip_nxt = 1'b0;
          end else if (data_byte == jscan_pkg::CH_BSLASH) begin
            skip_nxt = 1'b1;
          end else if (data_byte == jscan_pkg::CH_QUOTE) begin
            str_nxt = 1'b0;
            if (e_fill != '0 && top_mark == jscan_pkg::MARK_KEY) begin
              // value string after "key": closes the pair
              chunk_v = 1'b1;
              kind    = jscan_pkg::KIND_STR;
              hoff    = e_sstart;
              doff    = e_sstart + 1'b1;
              dlen    = jscan_pkg::LEN_W'(e_pos) - jscan_pkg::LEN_W'(e_sstart) - 1'b1;
              mark_we = 1'b1;
              wr_mark = jscan_pkg::MARK_NONE;
            end
          end
        end else begin
          unique case (data_byte) inside
            jscan_pkg::CH_QUOTE: begin
              str_nxt    = 1'b1;
              skip_nxt   = 1'b0;
              sstart_nxt = cur_off;
            end
            jscan_pkg::CH_LBRACE, jscan_pkg::CH_LBRACK: begin
              if (e_fill >= jscan_pkg::FILL_W'(jscan_pkg::MAX_DEPTH)) begin
                stop_nxt = 1'b1;
              end else begin
                off_we   = 1'b1;
                mark_we  = 1'b1;
                wr_idx   = push_idx;
                wr_mark  = (data_byte == jscan_pkg::CH_LBRACE) ?
                           jscan_pkg::MARK_OBJ : jscan_pkg::MARK_ARR;
                fill_nxt = e_fill + 1'b1;
              end
            end
            jscan_pkg::CH_RBRACE, jscan_pkg::CH_RBRACK: begin
              if (e_fill == '0) begin
                stop_nxt = 1'b1;
              end else begin
                // kind follows the closing byte, even on a mismatch
                fill_nxt = e_fill - 1'b1;
                chunk_v  = 1'b1;
                kind     = (data_byte == jscan_pkg::CH_RBRACE) ?
                           jscan_pkg::KIND_OBJ : jscan_pkg::KIND_ARR;
              end
            end
            jscan_pkg::CH_COLON: begin
              if (e_fill != '0 && top_mark == jscan_pkg::MARK_OBJ) begin
                mark_we = 1'b1;
                wr_mark = jscan_pkg::MARK_KEY;
              end
            end
            default: ;
          endcase
        end
        if (chunk_v) begin
          cnt_nxt = e_cnt + 1'b1;
          if (cnt_nxt >= jscan_pkg::CNT_W'(jscan_pkg::MAX_CHUNKS)) stop_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push.chunk_v             = proc && chunk_v;
    push.count_v             = proc && last_byte;
    push.chunk.record_type   = jscan_pkg::REC_CHUNK;
    push.chunk.chunk_kind    = kind;
    push.chunk.header_offset = hoff;
    push.chunk.data_offset   = doff;
    push.chunk.data_length   = dlen;
    push.chunk.chunk_count   = jscan_pkg::CNT_OUT_W'(cnt_nxt);
    push.chunk.last          = !last_byte;
    push.count.record_type   = jscan_pkg::REC_COUNT;
    push.count.chunk_kind    = jscan_pkg::KIND_STR;
    push.count.header_offset = '0;
    push.count.data_offset   = '0;
    push.count.data_length   = '0;
    push.count.chunk_count   = jscan_pkg::CNT_OUT_W'(cnt_nxt);
    push.count.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fill_r   <= '0;
      cnt_r    <= '0;
      str_r    <= 1'b0;
      skip_r   <= 1'b0;
      sstart_r <= '0;
      stop_r   <= 1'b0;
    end else if (proc) begin
      pos_r    <= pos_nxt;
      fill_r   <= fill_nxt;
      cnt_r    <= cnt_nxt;
      str_r    <= str_nxt;
      skip_r   <= skip_nxt;
      sstart_r <= sstart_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // frame stack: no reset, only entries below the fill are read
  always_ff @(posedge clk) begin
    if (proc && off_we)  offs_r[wr_idx]  <= cur_off;
    if (proc && mark_we) marks_r[wr_idx] <= wr_mark;
  end

endmodule

### sv/jscan_fifo.sv
// Result queue: takes up to two results per cycle, hands out one when pop_ready is high.
module jscan_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  jscan_pkg::push_t   push,
  output logic               space2,
  output logic               pop_valid,
  input  logic               pop_ready,
  output jscan_pkg::result_t pop_data
);

  jscan_pkg::result_t             mem_r [jscan_pkg::FIFO_DEPTH];
  logic [jscan_pkg::FIFO_AW-1:0]  head_r, head_nxt, tail_r, tail_nxt, tail2;
  logic [jscan_pkg::FIFO_CW-1:0]  cnt_r, cnt_nxt;
  logic                           pop;

  assign pop_valid = cnt_r != '0;
  assign pop_data  = mem_r[head_r];
  assign pop       = pop_valid && pop_ready;
  assign space2    = cnt_r <= jscan_pkg::FIFO_CW'(jscan_pkg::FIFO_DEPTH - 2);
  assign tail2     = tail_r + jscan_pkg::FIFO_AW'(push.chunk_v);

  always_comb begin
    head_nxt = head_r + jscan_pkg::FIFO_AW'(pop);
    tail_nxt = tail2 + jscan_pkg::FIFO_AW'(push.count_v);
    cnt_nxt  = cnt_r + jscan_pkg::FIFO_CW'(push.chunk_v)
             + jscan_pkg::FIFO_CW'(push.count_v) - jscan_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.chunk_v) mem_r[tail_r] <= push.chunk;
    if (push.count_v) mem_r[tail2]  <= push.count;
  end

endmodule
